/* hw/rtl/grid_wall_follower_top_defines.svh */
// Assertion macros for the grid wall follower.
// Used by grid_wall_follower_top; relies on signals named clock and reset in scope.
`ifndef GRID_WALL_FOLLOWER_TOP_DEFINES_SVH
`define GRID_WALL_FOLLOWER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GWF_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gwf assertion failed");
// next-cycle implication
`define GWF_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gwf assertion failed");
`else
`define GWF_ASSERT_IMP(name, ante, cons)
`define GWF_ASSERT_NEXT(name, ante, cons)
`endif

`endif

/* hw/rtl/gwf_pkg.sv */
// Shared types, codes and helpers for the grid wall follower.
// No dependencies.
package gwf_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CFG_W      = 7;
   // usable extent is capped by the store and by the 6-bit coordinate fields
   localparam int ROW_CAP    = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int COL_CAP    = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [1:0]        heading_type;
   typedef logic [1:0]        move_type;
   typedef logic [1:0]        req_kind_type;
   typedef logic [CFG_W-1:0]  coord_type;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam req_kind_type REQ_WRITE = 2'd0;
   localparam req_kind_type REQ_PLACE = 2'd1;
   localparam req_kind_type REQ_TICK  = 2'd2;

   localparam move_type MOVE_NONE = 2'd0;
   localparam move_type MOVE_CW   = 2'd1;
   localparam move_type MOVE_STEP = 2'd2;
   localparam move_type MOVE_CCW  = 2'd3;

   localparam heading_type HEAD_LEFT  = 2'd0;
   localparam heading_type HEAD_DOWN  = 2'd1;
   localparam heading_type HEAD_RIGHT = 2'd2;
   localparam heading_type HEAD_UP    = 2'd3;

   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   localparam coord_type COORD_PLUS  = 7'd1;
   localparam coord_type COORD_MINUS = 7'h7F;
   localparam coord_type COORD_ZERO  = 7'd0;

   // row offset of one step along heading h
   function automatic coord_type dir_row(heading_type h);
      coord_type d;
      case (h)
         HEAD_DOWN: d = COORD_PLUS;
         HEAD_UP:   d = COORD_MINUS;
         default:   d = COORD_ZERO;
      endcase
      return d;
   endfunction

   // column offset of one step along heading h
   function automatic coord_type dir_col(heading_type h);
      coord_type d;
      case (h)
         HEAD_LEFT:  d = COORD_MINUS;
         HEAD_RIGHT: d = COORD_PLUS;
         default:    d = COORD_ZERO;
      endcase
      return d;
   endfunction

   function automatic addr_type cell_addr(row_type r, col_type c);
      return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
   endfunction

endpackage

/* hw/rtl/gwf_channels.sv */
// Valid/ready channel interfaces for request and response items.
// Depends on gwf_pkg.
interface gwf_req_if import gwf_pkg::*; ();
   logic         valid;
   logic         ready;
   req_kind_type req_type;
   row_type      row;
   col_type      col;
   logic         cell_wall;
   heading_type  start_heading;

   modport source (output valid, req_type, row, col, cell_wall, start_heading,
                   input ready);
   modport sink   (input valid, req_type, row, col, cell_wall, start_heading,
                   output ready);
endinterface

interface gwf_rsp_if import gwf_pkg::*; ();
   logic        valid;
   logic        ready;
   row_type     walker_row;
   col_type     walker_col;
   heading_type walker_heading;
   move_type    move_done;

   modport source (output valid, walker_row, walker_col, walker_heading, move_done,
                   input ready);
   modport sink   (input valid, walker_row, walker_col, walker_heading, move_done,
                   output ready);
endinterface

/* hw/rtl/grid_wall_follower_top.sv */
// Grid wall follower (right-hand rule): wall map in a single-port RAM plus one walker.
// Depends on gwf_pkg, gwf_channels.sv and grid_wall_follower_top_defines.svh.
//
// Usage:
//  - req_chan (valid/ready) carries one item: write a map cell, place the walker,
//    or tick one move. rsp_chan returns exactly one item per request with the
//    walker position/heading after it and the move taken (none/cw/step/ccw).
//  - APB port sets grid_width (0x0) and grid_height (0x4); write only while idle.
//    Cells beyond the configured size read as walls.
//  - Sequencing: write/place/unused codes go from idle straight to the decide
//    state, a tick goes through ST_AHEAD first. The tick cost is set by the wall
//    RAM's single port: the right-hand cell and the cell ahead are read one after
//    the other.
//  - One item at a time: req ready is high only in the idle state.
//  - Reset: walker goes to (0,0) facing left, flag clear, grid size 64x64, then
//    a clearing pass zeroes all 4096 cells of the wall RAM; req ready stays low
//    during it (APB writes are still taken).
//  - Stall: the response register holds its item while rsp ready is low; a new
//    request is still accepted and waits in the decide stage until the slot frees.
`include "grid_wall_follower_top_defines.svh"

module grid_wall_follower_top import gwf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   gwf_req_if.sink           req_chan,
   gwf_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   // sequencer states
   localparam logic [1:0] ST_CLEAR  = 2'd0;  // zeroing the wall RAM after reset
   localparam logic [1:0] ST_IDLE   = 2'd1;  // ready; issues right-hand read
   localparam logic [1:0] ST_AHEAD  = 2'd2;  // issues read of the cell ahead
   localparam logic [1:0] ST_DECIDE = 2'd3;  // resolve move, load response

   logic [1:0]  state_ff, state_in;
   addr_type    clr_cnt_ff, clr_cnt_in;
   logic        is_tick_ff;
   logic        right_wall_ff;
   logic        mem_rd_ff;

   row_type     pos_row_ff, pos_row_in;
   col_type     pos_col_ff, pos_col_in;
   heading_type heading_ff, heading_in;
   logic        turned_ff, turned_in;

   coord_type   grid_width_ff, grid_width_in;
   coord_type   grid_height_ff, grid_height_in;

   logic        rsp_valid_ff, rsp_valid_in;
   row_type     rsp_row_ff;
   col_type     rsp_col_ff;
   heading_type rsp_heading_ff;
   move_type    rsp_move_ff;
   move_type    move_in;

   // wall map: one bit per cell, single port, registered read
   logic        wall_mem [CELL_COUNT];
   logic        mem_we;
   addr_type    mem_addr;
   logic        mem_wdata;

   logic        req_accept;
   logic        out_free;
   logic        out_load;
   logic        csr_write;

   coord_type   d_row, d_col;
   coord_type   row_x, col_x;
   coord_type   right_r, right_c, ahead_r, ahead_c;
   coord_type   row_lim, col_lim;
   logic        right_out, ahead_out;
   logic        right_free, ahead_free;
   addr_type    right_addr, ahead_addr;

   // ---------------------------------------------------------------- handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign out_load       = (state_ff == ST_DECIDE) && out_free;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.walker_row     = rsp_row_ff;
   assign rsp_chan.walker_col     = rsp_col_ff;
   assign rsp_chan.walker_heading = rsp_heading_ff;
   assign rsp_chan.move_done      = rsp_move_ff;

   // ---------------------------------------------------------------- neighbors
   // 7-bit wrapping coordinates: stepping off row/col 0 gives 127, which fails
   // the limit compare just like a cell past the far edge.
   assign d_row   = dir_row(heading_ff);
   assign d_col   = dir_col(heading_ff);
   assign row_x   = CFG_W'(pos_row_ff);
   assign col_x   = CFG_W'(pos_col_ff);
   assign right_r = row_x + d_col;
   assign right_c = col_x - d_row;
   assign ahead_r = row_x + d_row;
   assign ahead_c = col_x + d_col;

   assign row_lim = (grid_height_ff > CFG_W'(ROW_CAP)) ? CFG_W'(ROW_CAP) : grid_height_ff;
   assign col_lim = (grid_width_ff  > CFG_W'(COL_CAP)) ? CFG_W'(COL_CAP) : grid_width_ff;

   assign right_out = (right_r >= row_lim) || (right_c >= col_lim);
   assign ahead_out = (ahead_r >= row_lim) || (ahead_c >= col_lim);

   assign right_addr = cell_addr(right_r[ROW_W-1:0], right_c[COL_W-1:0]);
   assign ahead_addr = cell_addr(ahead_r[ROW_W-1:0], ahead_c[COL_W-1:0]);

   // right bit was latched in ST_AHEAD; ahead bit is the current RAM output
   assign right_free = !right_out && !right_wall_ff;
   assign ahead_free = !ahead_out && !mem_rd_ff;

   // ---------------------------------------------------------------- RAM port
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = right_addr;
      mem_wdata = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
         end
         ST_IDLE: begin
            // 6-bit fields always land inside the 64x64 store
            if (req_accept && (req_chan.req_type == REQ_WRITE)) begin
               mem_we    = 1'b1;
               mem_addr  = cell_addr(req_chan.row, req_chan.col);
               mem_wdata = req_chan.cell_wall;
            end
         end
         ST_AHEAD, ST_DECIDE: begin
            // keep reading the cell ahead so a stalled decide still sees its bit
            mem_addr = ahead_addr;
         end
         default: begin
            mem_addr = right_addr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wall_mem[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= wall_mem[mem_addr];
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_chan.req_type == REQ_TICK) ? ST_AHEAD : ST_DECIDE;
            end
         end
         ST_AHEAD: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- walker
   always_comb begin
      pos_row_in = pos_row_ff;
      pos_col_in = pos_col_ff;
      heading_in = heading_ff;
      turned_in  = turned_ff;
      move_in    = MOVE_NONE;
      if (req_accept && (req_chan.req_type == REQ_PLACE)) begin
         pos_row_in = req_chan.row;
         pos_col_in = req_chan.col;
         heading_in = req_chan.start_heading;
         turned_in  = 1'b0;
      end
      if ((state_ff == ST_DECIDE) && is_tick_ff) begin
         if (!turned_ff && right_free) begin
            heading_in = heading_ff + 2'd3;
            turned_in  = 1'b1;
            move_in    = MOVE_CW;
         end else if (ahead_free) begin
            pos_row_in = ahead_r[ROW_W-1:0];
            pos_col_in = ahead_c[COL_W-1:0];
            turned_in  = 1'b0;
            move_in    = MOVE_STEP;
         end else begin
            heading_in = heading_ff + 2'd1;
            move_in    = MOVE_CCW;
         end
      end
   end

   // ---------------------------------------------------------------- CSR
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write) begin
         case (paddr[CSR_AW-1])
            REG_GRID_WIDTH:  grid_width_in  = pwdata[CFG_W-1:0];
            REG_GRID_HEIGHT: grid_height_in = pwdata[CFG_W-1:0];
            default: begin
               grid_width_in = grid_width_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_AW-1])
         REG_GRID_WIDTH:  prdata = CSR_DW'(grid_width_ff);
         REG_GRID_HEIGHT: prdata = CSR_DW'(grid_height_ff);
         default:         prdata = '0;
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         pos_row_ff     <= '0;
         pos_col_ff     <= '0;
         heading_ff     <= HEAD_LEFT;
         turned_ff      <= 1'b0;
         grid_width_ff  <= CFG_W'(64);
         grid_height_ff <= CFG_W'(64);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         rsp_valid_ff   <= rsp_valid_in;
         // walker commits only on a request accept (place) or with the response load, so a stalled tick retries cleanly
         if (req_accept || out_load) begin
            pos_row_ff <= pos_row_in;
            pos_col_ff <= pos_col_in;
            heading_ff <= heading_in;
            turned_ff  <= turned_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         is_tick_ff <= (req_chan.req_type == REQ_TICK);
      end
      if (state_ff == ST_AHEAD) begin
         right_wall_ff <= mem_rd_ff;
      end
      if (out_load) begin
         rsp_row_ff     <= pos_row_in;
         rsp_col_ff     <= pos_col_in;
         rsp_heading_ff <= heading_in;
         rsp_move_ff    <= move_in;
      end
   end

   // ---------------------------------------------------------------- checks
   `GWF_ASSERT_IMP(a_we_phase, mem_we, (state_ff == ST_CLEAR) || (state_ff == ST_IDLE))
   `GWF_ASSERT_NEXT(a_step_moves, out_load && (move_in == MOVE_STEP), (pos_row_ff != $past(pos_row_ff)) || (pos_col_ff != $past(pos_col_ff)))
   `GWF_ASSERT_NEXT(a_turn_holds_pos, out_load && (move_in != MOVE_STEP), (pos_row_ff == $past(pos_row_ff)) && (pos_col_ff == $past(pos_col_ff)))
   `GWF_ASSERT_NEXT(a_cw_sets_flag, out_load && (move_in == MOVE_CW), turned_ff)

endmodule
